[hdl/pem_pkg.sv]
// Package for the Prewitt edge magnitude unit: payload structs, widths,
// register indexes, mode codes and the state type. No dependencies.
package pem_pkg;

   // Sizes and limits.
   localparam int DEFAULT_MAX_WIDTH = 2048;
   localparam int PIXEL_W           = 8;
   localparam int WIDTH_REG_W       = 12;
   localparam int HEIGHT_REG_W      = 16;
   localparam int MODE_W            = 2;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 16;
   localparam int GRAD_W            = 11;
   localparam int SQUARE_W          = 20;
   localparam int SUM_W             = 21;
   localparam int ROOT_W            = 16;
   localparam int ROOT_STEPS        = 8;
   localparam int MIN_DIM           = 3;

   // Reset values of the control registers.
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;
   localparam logic [PIXEL_W-1:0]      BYTE_MAX     = 8'd255;

   // Register indexes of the control port.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRADIENT_MODE = 2'd2;

   // Gradient mode codes; every other code selects the magnitude.
   localparam logic [MODE_W-1:0] MODE_MAGNITUDE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DX        = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DY        = 2'd2;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] edge_value;
      logic               frame_done;
   } rsp_type;

   // 3x3 window indexed [row][column]; row 0 is the upper row, column 2 the newest.
   typedef logic [2:0][2:0][PIXEL_W-1:0] window_type;

   // Beat carried along the square root chain.
   typedef struct packed {
      logic               valid;
      logic [ROOT_W-1:0]  v;
      logic [ROOT_W-1:0]  res;
      logic               use_root;
      logic [PIXEL_W-1:0] fixed_val;
      logic               done;
   } root_data_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_GRAD
   } state_type;

endpackage

[hdl/prewitt_edge_magnitude_unit.sv]
// Top level of the Prewitt edge magnitude unit: control registers, raster
// position, sequencer, square root chain and output register.
// Depends on pem_pkg, pem_window, pem_gradient and pem_root_cell.
//
// Usage: grey pixels enter in raster order on the req_ channel, one beat per
// pixel, with frame_start set on the first pixel of a frame. For each pixel at
// row r >= 1 and column c >= 1 one beat leaves on the rsp_ channel with the edge
// strength of the window centred at (r-1, c-1); the centre row 0 and column 0
// give 0, and frame_done marks the beat of the last pixel of a frame. The csr_
// port writes image width, image height and gradient mode; the user must write
// them only while the unit is idle, as the unit does not enforce it. Each pixel
// passes fetch, write back and gradient steps around the single line store memory
// before the input reopens, then 3 gradient stages and 8 square root cells.
// Reset (synchronous) restores the register defaults (640 x 480, magnitude) and
// the position to row 0, column 0; the line store needs no clearing pass.
// When the receiver stalls, the chain and the output register hold. Pixels that
// give no result still pass; the first pixel that gives one waits at the chain
// head and the input stays closed until the chain moves again.
module prewitt_edge_magnitude_unit #(
   parameter int MAX_WIDTH = pem_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pem_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pem_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [pem_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pem_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (WW > pem_pkg::WIDTH_REG_W) ? WW : pem_pkg::WIDTH_REG_W;
   localparam int HW   = pem_pkg::HEIGHT_REG_W;
   localparam int PW   = pem_pkg::PIXEL_W;
   localparam int NS   = pem_pkg::ROOT_STEPS;

   // Control registers.
   logic [pem_pkg::WIDTH_REG_W-1:0] width_ff;
   logic [HW-1:0]                   height_ff;
   logic [pem_pkg::MODE_W-1:0]      mode_ff;

   // Raster position and the captured facts of the pixel in work.
   logic [CW-1:0] column_count_ff, column_count_in;
   logic [HW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] pos_c_ff;
   logic          emit_ff, border_ff, done_ff;
   logic          emit_in, border_in, done_in;

   pem_pkg::state_type state_ff, state_in;

   logic [CMPW-1:0] eff_w, w_ext, col_base, c_cur, c_next;
   logic [HW-1:0]   eff_h, r_cur;
   logic [HW:0]     row_base, r_step, r_next;
   logic            wrap_col, last_col;

   logic accept, wb_en, push, chain_move;
   pem_pkg::window_type    window;
   pem_pkg::root_data_type chain [NS+1];
   logic                   rsp_valid_ff;
   pem_pkg::rsp_type       rsp_data_ff;

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pem_pkg::WIDTH_RESET;
         height_ff <= pem_pkg::HEIGHT_RESET;
         mode_ff   <= pem_pkg::MODE_MAGNITUDE;
      end else if (csr_write) begin
         case (csr_index)
            pem_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_data[pem_pkg::WIDTH_REG_W-1:0];
            end
            pem_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_data[HW-1:0];
            end
            pem_pkg::CSR_GRADIENT_MODE: begin
               mode_ff <= csr_data[pem_pkg::MODE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective frame size, clamped to the supported range.
   always_comb begin
      w_ext = CMPW'(width_ff);
      if (w_ext < CMPW'(pem_pkg::MIN_DIM)) begin
         eff_w = CMPW'(pem_pkg::MIN_DIM);
      end else if (w_ext > CMPW'(MAX_WIDTH)) begin
         eff_w = CMPW'(MAX_WIDTH);
      end else begin
         eff_w = w_ext;
      end
      eff_h = (height_ff < HW'(pem_pkg::MIN_DIM)) ? HW'(pem_pkg::MIN_DIM) : height_ff;
   end

   // Position of the incoming pixel and of the one after it.
   always_comb begin
      col_base = req_data.frame_start ? '0 : CMPW'(column_count_ff);
      row_base = req_data.frame_start ? '0 : {1'b0, row_count_ff};
      wrap_col = (col_base >= eff_w);
      c_cur    = wrap_col ? '0 : col_base;
      r_step   = wrap_col ? (row_base + 1'b1) : row_base;
      r_cur    = (r_step >= {1'b0, eff_h}) ? '0 : r_step[HW-1:0];
      c_next   = c_cur + 1'b1;
      r_next   = {1'b0, r_cur} + 1'b1;
      last_col = (c_next >= eff_w);
      if (last_col) begin
         column_count_in = '0;
         row_count_in    = (r_next >= {1'b0, eff_h}) ? '0 : r_next[HW-1:0];
      end else begin
         column_count_in = c_next[CW-1:0];
         row_count_in    = r_cur;
      end
      emit_in   = (r_cur != '0) && (c_cur != '0);
      border_in = (r_cur == HW'(1)) || (c_cur == CMPW'(1));
      done_in   = (r_cur == (eff_h - 1'b1)) && (c_cur == (eff_w - 1'b1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         emit_ff         <= 1'b0;
      end else if (accept) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         emit_ff         <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_c_ff  <= c_cur[CW-1:0];
         border_ff <= border_in;
         done_ff   <= done_in;
      end
   end

   // Sequencer: fetch on accept, write back and slide, then hand to the gradient.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pem_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pem_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pem_pkg::ST_UPDATE;
            end
         end
         pem_pkg::ST_UPDATE: begin
            state_in = pem_pkg::ST_GRAD;
         end
         pem_pkg::ST_GRAD: begin
            if (!emit_ff || chain_move) begin
               state_in = pem_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pem_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      wb_en     = 1'b0;
      push      = 1'b0;
      case (state_ff)
         pem_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         pem_pkg::ST_UPDATE: begin
            wb_en = 1'b1;
         end
         pem_pkg::ST_GRAD: begin
            push = emit_ff && chain_move;
         end
         default: begin
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // The whole chain advances unless a finished beat is waiting at the output.
   assign chain_move = !rsp_valid_ff || rsp_ready;

   pem_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (c_cur[CW-1:0]),
      .pixel   (req_data.pixel),
      .wr_en   (wb_en),
      .wr_addr (pos_c_ff),
      .window  (window)
   );

   pem_gradient u_gradient (
      .clock  (clock),
      .reset  (reset),
      .move   (chain_move),
      .push   (push),
      .mode   (mode_ff),
      .border (border_ff),
      .done   (done_ff),
      .window (window),
      .head   (chain[0])
   );

   // Square root chain, one restoring step per cell.
   for (genvar i = 0; i < NS; i++) begin : g_root
      pem_root_cell #(
         .STEP (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .move     (chain_move),
         .beat_in  (chain[i]),
         .beat_out (chain[i+1])
      );
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_move) begin
         rsp_valid_ff <= chain[NS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_move) begin
         rsp_data_ff.edge_value <= chain[NS].use_root ? chain[NS].res[PW-1:0]
                                                      : chain[NS].fixed_val;
         rsp_data_ff.frame_done <= chain[NS].done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A taken pixel keeps the input closed for at least the next cycle.
   a_accept_closes_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after an accepted beat");

   // The stored column always lies inside the current row.
   a_column_in_row: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !csr_write) |=> (CMPW'(column_count_ff) < eff_w))
      else $error("column count beyond image width");

   // A new result only appears when the last cell held a beat.
   a_rsp_from_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(chain[NS].valid))
      else $error("result beat without a beat in the last cell");

endmodule

[hdl/pem_window.sv]
// Line store memory and 3x3 window of the Prewitt edge magnitude unit.
// Depends on pem_pkg.
module pem_window #(
   parameter int MAX_WIDTH = pem_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
   input  logic [pem_pkg::PIXEL_W-1:0]     pixel,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
   output pem_pkg::window_type             window
);

   localparam int PW = pem_pkg::PIXEL_W;

   // Each entry holds {upper row byte, middle row byte} of one column.
   logic [2*PW-1:0] store_mem [MAX_WIDTH];
   logic [2*PW-1:0] rd_data_ff;
   logic [PW-1:0]   pixel_ff;
   pem_pkg::window_type window_ff;
   pem_pkg::window_type window_in;

   // Read the column's two stored rows when the pixel is taken.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
         pixel_ff   <= pixel;
      end
   end

   // Write back: the middle row moves up and the new pixel becomes the middle row.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= {rd_data_ff[PW-1:0], pixel_ff};
      end
   end

   // Slide the window left by one column and insert the fetched column.
   always_comb begin
      window_in = window_ff;
      for (int k = 0; k < 3; k++) begin
         window_in[k][0] = window_ff[k][1];
         window_in[k][1] = window_ff[k][2];
      end
      window_in[0][2] = rd_data_ff[2*PW-1:PW];
      window_in[1][2] = rd_data_ff[PW-1:0];
      window_in[2][2] = pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (wr_en) begin
         window_ff <= window_in;
      end
   end

   assign window = window_ff;

endmodule

[hdl/pem_gradient.sv]
// Gradient front of the Prewitt edge magnitude unit: dx and dy, their squares,
// the sum with saturation, and the result for the directional modes. Depends on pem_pkg.
module pem_gradient (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          move,
   input  logic                          push,
   input  logic [pem_pkg::MODE_W-1:0]    mode,
   input  logic                          border,
   input  logic                          done,
   input  pem_pkg::window_type           window,
   output pem_pkg::root_data_type        head
);

   localparam int PW = pem_pkg::PIXEL_W;
   localparam int GW = pem_pkg::GRAD_W;
   localparam int SW = pem_pkg::SQUARE_W;
   localparam int UW = pem_pkg::SUM_W;
   localparam int RW = pem_pkg::ROOT_W;

   // Stage 1: gradients.
   logic                 p1_valid_ff;
   logic signed [GW-1:0] p1_dx_ff, p1_dy_ff;
   logic                 p1_border_ff, p1_done_ff;
   logic [GW-2:0]        col_right, col_left, row_low, row_up;
   logic signed [GW-1:0] dx_in, dy_in;

   // Stage 2: squares and clamped gradients.
   logic                 p2_valid_ff;
   logic [SW-1:0]        p2_sqx_ff, p2_sqy_ff;
   logic [PW-1:0]        p2_clx_ff, p2_cly_ff;
   logic                 p2_border_ff, p2_done_ff;
   logic signed [2*GW-1:0] prod_x, prod_y;
   logic [PW-1:0]        clx_in, cly_in;

   // Stage 3: sum and result selection.
   pem_pkg::root_data_type head_ff;
   pem_pkg::root_data_type head_in;
   logic [UW-1:0]        sum;
   logic                 sat, is_mag;

   // Column and row sums of the window.
   always_comb begin
      col_right = (GW-1)'(window[0][2]) + (GW-1)'(window[1][2]) + (GW-1)'(window[2][2]);
      col_left  = (GW-1)'(window[0][0]) + (GW-1)'(window[1][0]) + (GW-1)'(window[2][0]);
      row_low   = (GW-1)'(window[2][0]) + (GW-1)'(window[2][1]) + (GW-1)'(window[2][2]);
      row_up    = (GW-1)'(window[0][0]) + (GW-1)'(window[0][1]) + (GW-1)'(window[0][2]);
      dx_in     = $signed({1'b0, col_right}) - $signed({1'b0, col_left});
      dy_in     = $signed({1'b0, row_low}) - $signed({1'b0, row_up});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (move) begin
         p1_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         p1_dx_ff     <= dx_in;
         p1_dy_ff     <= dy_in;
         p1_border_ff <= border;
         p1_done_ff   <= done;
      end
   end

   // Squares, and the gradients clamped to a byte.
   always_comb begin
      prod_x = p1_dx_ff * p1_dx_ff;
      prod_y = p1_dy_ff * p1_dy_ff;
      if (p1_dx_ff < 0) begin
         clx_in = '0;
      end else if (p1_dx_ff > $signed(GW'(pem_pkg::BYTE_MAX))) begin
         clx_in = pem_pkg::BYTE_MAX;
      end else begin
         clx_in = p1_dx_ff[PW-1:0];
      end
      if (p1_dy_ff < 0) begin
         cly_in = '0;
      end else if (p1_dy_ff > $signed(GW'(pem_pkg::BYTE_MAX))) begin
         cly_in = pem_pkg::BYTE_MAX;
      end else begin
         cly_in = p1_dy_ff[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (move) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         p2_sqx_ff    <= prod_x[SW-1:0];
         p2_sqy_ff    <= prod_y[SW-1:0];
         p2_clx_ff    <= clx_in;
         p2_cly_ff    <= cly_in;
         p2_border_ff <= p1_border_ff;
         p2_done_ff   <= p1_done_ff;
      end
   end

   // Sum of squares; anything at or above 2^16 saturates to full scale.
   always_comb begin
      sum    = {1'b0, p2_sqx_ff} + {1'b0, p2_sqy_ff};
      sat    = (sum[UW-1:RW] != '0);
      is_mag = (mode != pem_pkg::MODE_DX) && (mode != pem_pkg::MODE_DY);
      head_in.valid    = p2_valid_ff;
      head_in.v        = sum[RW-1:0];
      head_in.res      = '0;
      head_in.use_root = is_mag && !p2_border_ff && !sat;
      head_in.done     = p2_done_ff;
      if (p2_border_ff) begin
         head_in.fixed_val = '0;
      end else if (mode == pem_pkg::MODE_DX) begin
         head_in.fixed_val = p2_clx_ff;
      end else if (mode == pem_pkg::MODE_DY) begin
         head_in.fixed_val = p2_cly_ff;
      end else begin
         head_in.fixed_val = pem_pkg::BYTE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (move) begin
         head_ff.valid <= head_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         head_ff.v         <= head_in.v;
         head_ff.res       <= head_in.res;
         head_ff.use_root  <= head_in.use_root;
         head_ff.fixed_val <= head_in.fixed_val;
         head_ff.done      <= head_in.done;
      end
   end

   assign head = head_ff;

endmodule

[hdl/pem_root_cell.sv]
// One cell of the square root chain: a single restoring step of the integer
// square root, registered. Depends on pem_pkg.
module pem_root_cell #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    move,
   input  pem_pkg::root_data_type  beat_in,
   output pem_pkg::root_data_type  beat_out
);

   localparam int RW    = pem_pkg::ROOT_W;
   localparam int SHIFT = 2 * (pem_pkg::ROOT_STEPS - 1 - STEP);
   localparam logic [RW:0] BIT = (RW+1)'(1) << SHIFT;

   pem_pkg::root_data_type cell_ff;
   pem_pkg::root_data_type cell_in;
   logic [RW:0] trial;

   // Try to subtract res + bit; keep the root bit when it fits.
   always_comb begin
      cell_in = beat_in;
      trial   = {1'b0, beat_in.res} + BIT;
      if (beat_in.use_root && ({1'b0, beat_in.v} >= trial)) begin
         cell_in.v   = beat_in.v - trial[RW-1:0];
         cell_in.res = (beat_in.res >> 1) + BIT[RW-1:0];
      end else begin
         cell_in.res = beat_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (move) begin
         cell_ff.valid <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         cell_ff.v         <= cell_in.v;
         cell_ff.res       <= cell_in.res;
         cell_ff.use_root  <= cell_in.use_root;
         cell_ff.fixed_val <= cell_in.fixed_val;
         cell_ff.done      <= cell_in.done;
      end
   end

   assign beat_out = cell_ff;

endmodule

[sim/tb_prewitt_edge_magnitude_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for prewitt_edge_magnitude_unit: pixel frames under many
// register settings, every result beat checked against a filter predictor or a typed result.
// Depends on pem_pkg and the RTL of the unit.
module tb_prewitt_edge_magnitude_unit;

   localparam int MAX_COLS         = pem_pkg::DEFAULT_MAX_WIDTH;
   localparam int PW               = pem_pkg::PIXEL_W;
   localparam int WRW              = pem_pkg::WIDTH_REG_W;
   localparam int HRW              = pem_pkg::HEIGHT_REG_W;
   localparam int MW               = pem_pkg::MODE_W;
   localparam int IW               = pem_pkg::CSR_INDEX_W;
   localparam int DW               = pem_pkg::CSR_DATA_W;
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int RANDOM_ITEMS     = 200;
   localparam int EXTREME_ITEMS    = 64;
   localparam int MISMATCH_REPORTS = 10;
   localparam logic [MW-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [MW-1:0]    mode;
      pem_pkg::req_type beat;
      logic             typed;
      pem_pkg::rsp_type result;
   } directed_row_type;

   // Three 3x3 frames; typed results hold the border zeros and the clamped centres (255, 255, 0).
   localparam directed_row_type DIRECTED_ROWS [27] = '{
      '{pem_pkg::MODE_MAGNITUDE, '{8'd0,   1'b1}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_MAGNITUDE, '{8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_MAGNITUDE, '{8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_MAGNITUDE, '{8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_MAGNITUDE, '{8'd0,   1'b0}, 1'b1, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_MAGNITUDE, '{8'd0,   1'b0}, 1'b1, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_MAGNITUDE, '{8'd255, 1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_MAGNITUDE, '{8'd255, 1'b0}, 1'b1, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_MAGNITUDE, '{8'd255, 1'b0}, 1'b1, '{8'd255, 1'b1}},
      '{pem_pkg::MODE_DX,        '{8'd0,   1'b1}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DX,        '{8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DX,        '{8'd255, 1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DX,        '{8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DX,        '{8'd0,   1'b0}, 1'b1, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DX,        '{8'd255, 1'b0}, 1'b1, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DX,        '{8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DX,        '{8'd0,   1'b0}, 1'b1, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DX,        '{8'd255, 1'b0}, 1'b1, '{8'd255, 1'b1}},
      '{pem_pkg::MODE_DY,        '{8'd255, 1'b1}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DY,        '{8'd255, 1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DY,        '{8'd255, 1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DY,        '{8'd128, 1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DY,        '{8'd128, 1'b0}, 1'b1, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DY,        '{8'd128, 1'b0}, 1'b1, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DY,        '{8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DY,        '{8'd0,   1'b0}, 1'b1, '{8'd0,   1'b0}},
      '{pem_pkg::MODE_DY,        '{8'd0,   1'b0}, 1'b1, '{8'd0,   1'b1}}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   pem_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   pem_pkg::rsp_type rsp_data;
   logic             csr_write;
   logic [IW-1:0]    csr_index;
   logic [DW-1:0]    csr_data;

   // Predictor copy of the registers, line stores, window and raster position.
   logic [WRW-1:0]      model_width;
   logic [HRW-1:0]      model_height;
   logic [MW-1:0]       model_mode;
   logic [PW-1:0]       newer_line [MAX_COLS];
   logic [PW-1:0]       older_line [MAX_COLS];
   logic [1:0]          line_fill  [MAX_COLS];
   pem_pkg::window_type model_window;
   logic [HRW-1:0]      model_row;
   logic [10:0]         model_col;

   pem_pkg::rsp_type edge_queue [$];
   int               error_count  = 0;
   logic             hold_request = 1'b0;

   prewitt_edge_magnitude_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Width actually used by the filter: clamped to the legal range.
   function automatic int effective_width();
      if (model_width < pem_pkg::MIN_DIM) return pem_pkg::MIN_DIM;
      if (model_width > MAX_COLS) return MAX_COLS;
      return int'(model_width);
   endfunction

   // Advances the predictor by one pixel; returns 1 when the pixel causes a result.
   function automatic logic predict_edge(input pem_pkg::req_type beat,
                                         output pem_pkg::rsp_type result);
      int w, h, r, c, dx, dy, sq, root, trial;
      logic [PW-1:0] upper, middle;
      w = effective_width();
      h = (model_height < pem_pkg::MIN_DIM) ? pem_pkg::MIN_DIM : int'(model_height);
      r = model_row;
      c = model_col;
      if (beat.frame_start) begin
         r = 0;
         c = 0;
      end
      // A position left beyond the frame by a register change wraps around.
      if (c >= w) begin
         c = 0;
         r = r + 1;
      end
      if (r >= h) r = 0;

      upper  = older_line[c];
      middle = newer_line[c];
      older_line[c] = middle;
      newer_line[c] = beat.pixel;
      if (line_fill[c] != 2'd2) line_fill[c] = line_fill[c] + 2'd1;

      for (int k = 0; k < 3; k++) begin
         model_window[k][0] = model_window[k][1];
         model_window[k][1] = model_window[k][2];
      end
      model_window[0][2] = upper;
      model_window[1][2] = middle;
      model_window[2][2] = beat.pixel;

      predict_edge      = (r >= 1) && (c >= 1);
      result.frame_done = (r == h - 1) && (c == w - 1);
      result.edge_value = '0;
      // Centres in row 0 or column 0 stay at zero.
      if (r >= 2 && c >= 2) begin
         dx = 0;
         dy = 0;
         for (int k = 0; k < 3; k++) begin
            dx += int'(model_window[k][2]) - int'(model_window[k][0]);
            dy += int'(model_window[2][k]) - int'(model_window[0][k]);
         end
         case (model_mode)
            pem_pkg::MODE_DX: result.edge_value = (dx < 0) ? 8'd0 :
                                                  (dx > 255) ? pem_pkg::BYTE_MAX : PW'(dx);
            pem_pkg::MODE_DY: result.edge_value = (dy < 0) ? 8'd0 :
                                                  (dy > 255) ? pem_pkg::BYTE_MAX : PW'(dy);
            default: begin
               sq = dx * dx + dy * dy;
               if (sq >= 65536) begin
                  result.edge_value = pem_pkg::BYTE_MAX;
               end else begin
                  // Integer square root, one result bit at a time.
                  root = 0;
                  for (int b = 7; b >= 0; b--) begin
                     trial = root | (1 << b);
                     if (trial * trial <= sq) root = trial;
                  end
                  result.edge_value = PW'(root);
               end
            end
         endcase
      end

      if (c + 1 >= w) begin
         c = 0;
         r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         c = c + 1;
      end
      model_row = HRW'(r);
      model_col = 11'(c);
   endfunction

   // One register write; called and returning at a falling edge.
   task automatic write_register(input logic [IW-1:0] index,
                                 input logic [DW-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
      case (index)
         pem_pkg::CSR_IMAGE_WIDTH:   model_width  = value[WRW-1:0];
         pem_pkg::CSR_IMAGE_HEIGHT:  model_height = value[HRW-1:0];
         pem_pkg::CSR_GRADIENT_MODE: model_mode   = value[MW-1:0];
         default: ;
      endcase
   endtask

   // Writes all three registers; unused upper data bits carry random noise.
   task automatic set_registers(input logic [WRW-1:0] width_value,
                                input logic [HRW-1:0] height_value,
                                input logic [MW-1:0] mode_value);
      write_register(pem_pkg::CSR_IMAGE_WIDTH, {4'($urandom), width_value});
      write_register(pem_pkg::CSR_IMAGE_HEIGHT, height_value);
      write_register(pem_pkg::CSR_GRADIENT_MODE, {14'($urandom), mode_value});
      csr_write <= 1'b0;
   endtask

   // Sender pause: every expected result in, then time for a result-less pixel in flight.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (edge_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Offers one pixel beat after a gap and records what it should produce.
   task automatic send_pixel(input pem_pkg::req_type beat, input int gap,
                             input logic typed, input pem_pkg::rsp_type typed_result);
      pem_pkg::rsp_type predicted;
      logic             emits;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      emits = predict_edge(beat, predicted);
      if (typed) edge_queue.push_back(typed_result);
      else if (emits) edge_queue.push_back(predicted);
      @(negedge clock);
   endtask

   // One register setting followed by a run of mostly well-formed frames.
   task automatic run_phase(input logic [WRW-1:0] width_value,
                            input logic [HRW-1:0] height_value,
                            input logic [MW-1:0] mode_value, input int count,
                            input logic keep_position, input logic long_hold);
      pem_pkg::req_type beat;
      int               gap_max;
      logic             restart;
      wait_for_idle();
      set_registers(width_value, height_value, mode_value);
      // Keeping the old position is only safe where both line stores hold data.
      restart = !keep_position;
      for (int c = 0; c < effective_width(); c++)
         if (line_fill[c] != 2'd2) restart = 1'b1;
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      if (long_hold) hold_request = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n == 0 && restart)
            beat.frame_start = 1'b1;
         else if (model_row == 0 && model_col == 0)
            beat.frame_start = ($urandom_range(0, 7) != 0);
         else
            beat.frame_start = ($urandom_range(0, 63) == 0);
         case ($urandom_range(0, 3))
            0: beat.pixel = PW'($urandom);
            1: beat.pixel = ($urandom_range(0, 1) != 0) ? pem_pkg::BYTE_MAX : 8'd0;
            2: beat.pixel = PW'(model_col * 37 + model_row * 11 + $urandom_range(0, 7));
            default: beat.pixel = PW'($urandom_range(100, 140));
         endcase
         send_pixel(beat, $urandom_range(0, gap_max), 1'b0, '0);
      end
   endtask

   // Result side: random stalls, an occasional long hold-off, and the check.
   initial begin : result_checker
      int               gap;
      int               result_count;
      logic             rx_burst;
      pem_pkg::rsp_type wanted;
      rsp_ready = 1'b0;
      result_count = 0;
      rx_burst = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            gap = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end else if (rx_burst) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 5);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (edge_queue.size() == 0) begin
            error_count++;
            if (error_count <= MISMATCH_REPORTS)
               $display("result beat %0d with nothing expected: edge %0d done %b",
                        result_count, rsp_data.edge_value, rsp_data.frame_done);
         end else begin
            wanted = edge_queue.pop_front();
            if (rsp_data.edge_value !== wanted.edge_value ||
                rsp_data.frame_done !== wanted.frame_done) begin
               error_count++;
               if (error_count <= MISMATCH_REPORTS)
                  $display("result beat %0d: expected edge %0d done %b, got edge %0d done %b",
                           result_count, wanted.edge_value, wanted.frame_done,
                           rsp_data.edge_value, rsp_data.frame_done);
            end
         end
         result_count++;
         if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      directed_row_type row;
      int               random_items;
      int               count;
      logic [WRW-1:0]   width_value;
      logic [HRW-1:0]   height_value;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      model_width  = pem_pkg::WIDTH_RESET;
      model_height = pem_pkg::HEIGHT_RESET;
      model_mode   = pem_pkg::MODE_MAGNITUDE;
      model_window = '0;
      model_row    = '0;
      model_col    = '0;
      for (int c = 0; c < MAX_COLS; c++) begin
         newer_line[c] = '0;
         older_line[c] = '0;
         line_fill[c]  = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames, one per gradient mode.
      set_registers(12'd3, 16'd3, pem_pkg::MODE_MAGNITUDE);
      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         if (row.mode != model_mode) begin
            wait_for_idle();
            set_registers(12'd3, 16'd3, row.mode);
         end
         send_pixel(row.beat, $urandom_range(0, 5), row.typed, row.result);
      end

      // Register extremes: widest frame, clamped sizes, spare mode, tallest frame.
      run_phase(12'd2048, 16'd3, pem_pkg::MODE_MAGNITUDE, EXTREME_ITEMS, 1'b0, 1'b1);
      run_phase(12'hFFF, 16'd0, MODE_SPARE, EXTREME_ITEMS, 1'b0, 1'b0);
      run_phase(12'd1, 16'd2, pem_pkg::MODE_DX, 30, 1'b0, 1'b0);
      run_phase(12'd5, 16'hFFFF, pem_pkg::MODE_DY, 60, 1'b0, 1'b1);

      // Random settings, mostly small frames.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       width_value = WRW'($urandom_range(0, 2));
            1:       width_value = WRW'($urandom_range(11, 64));
            default: width_value = WRW'($urandom_range(3, 10));
         endcase
         height_value = ($urandom_range(0, 9) == 0) ? HRW'($urandom_range(0, 2))
                                                    : HRW'($urandom_range(3, 6));
         count = $urandom_range(15, 60);
         run_phase(width_value, height_value, MW'($urandom_range(0, 3)), count,
                   1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
         random_items += count;
      end

      wait_for_idle();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : run_limit
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
hdl/pem_pkg.sv
hdl/pem_window.sv
hdl/pem_gradient.sv
hdl/pem_root_cell.sv
hdl/prewitt_edge_magnitude_unit.sv
sim/tb_prewitt_edge_magnitude_unit.sv
